// File: sv/c6502dec_pkg.sv
// shared types, constants and opcode table for the 6502 opcode decoder
package c6502dec_pkg;

	localparam int OpcodeWidth = 8;
	localparam int CodeWidth   = 7;
	localparam int ModeWidth   = 4;
	localparam int InDataWidth  = 8;
	localparam int OutDataWidth = 16;

	// opcode byte fields
	localparam int RowMsb = 7;
	localparam int RowLsb = 5;
	localparam int ColMsb = 4;
	localparam int ColLsb = 2;
	localparam int GrpMsb = 1;
	localparam int GrpLsb = 0;

	localparam logic [2:0] RowBitJmp = 3'd1;
	localparam logic [2:0] RowJmpInd = 3'd3;
	localparam logic [2:0] RowLastImp = 3'd3;
	localparam logic [2:0] RowStore = 3'd4;
	localparam logic [2:0] RowLoad  = 3'd5;

	localparam logic [1:0] GrpCtl = 2'd0;
	localparam logic [1:0] GrpAlu = 2'd1;
	localparam logic [1:0] GrpRmw = 2'd2;
	localparam logic [1:0] GrpIll = 2'd3;

	localparam logic [2:0] ColZpInd  = 3'd0;
	localparam logic [2:0] ColZp     = 3'd1;
	localparam logic [2:0] ColImm    = 3'd2;
	localparam logic [2:0] ColAbs    = 3'd3;
	localparam logic [2:0] ColIndY   = 3'd4;
	localparam logic [2:0] ColZpIdx  = 3'd5;
	localparam logic [2:0] ColAbsY   = 3'd6;
	localparam logic [2:0] ColAbsIdx = 3'd7;

	localparam logic [CodeWidth-1:0] InsnLast = 7'd76;
	localparam logic [OpcodeWidth-1:0] OpJmpInd = 8'h6C;

	typedef enum logic [ModeWidth-1:0] {
		AM_IMP = 4'd0,
		AM_ACC = 4'd1,
		AM_IMM = 4'd2,
		AM_ZP  = 4'd3,
		AM_ZPX = 4'd4,
		AM_ZPY = 4'd5,
		AM_ABS = 4'd6,
		AM_ABX = 4'd7,
		AM_ABY = 4'd8,
		AM_IND = 4'd9,
		AM_IZX = 4'd10,
		AM_IZY = 4'd11,
		AM_REL = 4'd12
	} addr_mode_t;

	typedef struct packed {
		logic [CodeWidth-1:0] code;
		addr_mode_t           mode;
	} dec_result_t;

	// instruction numbers indexed by {group, row, column}
	localparam logic [CodeWidth-1:0] INSN_TAB [256] = '{
		// group 0
		7'd0,  7'd1,  7'd2,  7'd1,  7'd3,  7'd1,  7'd4,  7'd1,
		7'd5,  7'd6,  7'd7,  7'd6,  7'd8,  7'd1,  7'd9,  7'd1,
		7'd10, 7'd1,  7'd11, 7'd12, 7'd13, 7'd1,  7'd14, 7'd1,
		7'd15, 7'd1,  7'd16, 7'd12, 7'd17, 7'd1,  7'd18, 7'd1,
		7'd1,  7'd19, 7'd20, 7'd19, 7'd21, 7'd19, 7'd22, 7'd23,
		7'd24, 7'd24, 7'd25, 7'd24, 7'd26, 7'd24, 7'd27, 7'd24,
		7'd28, 7'd28, 7'd29, 7'd28, 7'd30, 7'd1,  7'd31, 7'd1,
		7'd32, 7'd32, 7'd33, 7'd32, 7'd34, 7'd1,  7'd35, 7'd1,
		// group 1
		7'd36, 7'd36, 7'd36, 7'd36, 7'd36, 7'd36, 7'd36, 7'd36,
		7'd37, 7'd37, 7'd37, 7'd37, 7'd37, 7'd37, 7'd37, 7'd37,
		7'd38, 7'd38, 7'd38, 7'd38, 7'd38, 7'd38, 7'd38, 7'd38,
		7'd39, 7'd39, 7'd39, 7'd39, 7'd39, 7'd39, 7'd39, 7'd39,
		7'd40, 7'd40, 7'd1,  7'd40, 7'd40, 7'd40, 7'd40, 7'd40,
		7'd41, 7'd41, 7'd41, 7'd41, 7'd41, 7'd41, 7'd41, 7'd41,
		7'd42, 7'd42, 7'd42, 7'd42, 7'd42, 7'd42, 7'd42, 7'd42,
		7'd43, 7'd43, 7'd43, 7'd43, 7'd43, 7'd43, 7'd43, 7'd43,
		// group 2
		7'd44, 7'd45, 7'd45, 7'd45, 7'd44, 7'd45, 7'd1,  7'd45,
		7'd44, 7'd46, 7'd46, 7'd46, 7'd44, 7'd46, 7'd1,  7'd46,
		7'd44, 7'd47, 7'd47, 7'd47, 7'd44, 7'd47, 7'd1,  7'd47,
		7'd44, 7'd48, 7'd48, 7'd48, 7'd44, 7'd48, 7'd1,  7'd48,
		7'd1,  7'd49, 7'd50, 7'd49, 7'd44, 7'd49, 7'd51, 7'd52,
		7'd53, 7'd53, 7'd54, 7'd53, 7'd44, 7'd53, 7'd55, 7'd53,
		7'd1,  7'd56, 7'd57, 7'd56, 7'd44, 7'd56, 7'd1,  7'd56,
		7'd1,  7'd58, 7'd1,  7'd58, 7'd44, 7'd58, 7'd1,  7'd58,
		// group 3
		7'd59, 7'd59, 7'd60, 7'd59, 7'd59, 7'd59, 7'd59, 7'd59,
		7'd61, 7'd61, 7'd60, 7'd61, 7'd61, 7'd61, 7'd61, 7'd61,
		7'd62, 7'd62, 7'd63, 7'd62, 7'd62, 7'd62, 7'd62, 7'd62,
		7'd64, 7'd64, 7'd65, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64,
		7'd66, 7'd66, 7'd67, 7'd66, 7'd68, 7'd66, 7'd69, 7'd68,
		7'd70, 7'd70, 7'd71, 7'd70, 7'd70, 7'd70, 7'd72, 7'd70,
		7'd73, 7'd73, 7'd74, 7'd73, 7'd73, 7'd73, 7'd73, 7'd73,
		7'd75, 7'd75, 7'd76, 7'd75, 7'd75, 7'd75, 7'd75, 7'd75
	};

endpackage

// File: sv/cpu6502_opcode_decoder_unit.sv
// top level of the 6502 opcode decoder: input register, decode, result register
//
//   channel  dir  item                         tdata bits
//   s_*      in   one opcode byte              [7:0] opcode_byte
//   m_*      out  decoded instruction + mode   [6:0] instruction_code, [10:7] address_mode
//
// one item per cycle sustained while m_tready is high; the result passes both registers
// the decode sits between the opcode register (_s1) and the result register (_s2)
// arst_n clears both valid flags; the data registers are not reset
// a stall on m_tready holds the result; s_tready drops only when both stages are full
module cpu6502_opcode_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] opcode_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [6:0] instruction_code, [10:7] address_mode, rest zero
);

	logic                                       valid_s1;
	logic [c6502dec_pkg::OpcodeWidth-1:0]       opcode_s1;
	logic                                       valid_s2;
	c6502dec_pkg::dec_result_t                  result_s2;
	c6502dec_pkg::dec_result_t                  dec_result;
	logic                                       adv_s2;
	logic                                       adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign adv_s1   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			opcode_s1 <= s_tdata[c6502dec_pkg::OpcodeWidth-1:0];
		end
	end

	c6502dec_decode u_decode (
		.opcode (opcode_s1),
		.result (dec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= dec_result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(c6502dec_pkg::OutDataWidth - c6502dec_pkg::CodeWidth
		- c6502dec_pkg::ModeWidth){1'b0}}, result_s2.mode, result_s2.code};

	// empty opcode stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input not ready with empty opcode stage");

	// both stages full and output stalled: nothing may enter
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted into a full pipeline");

	// jump indirect must decode to the indirect mode
	a_jmp_ind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && opcode_s1 == c6502dec_pkg::OpJmpInd)
		|=> (result_s2.mode == c6502dec_pkg::AM_IND))
		else $error("jump indirect decoded to wrong mode");

	// presented result stays inside the code and mode ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_s2.code <= c6502dec_pkg::InsnLast
			&& result_s2.mode <= c6502dec_pkg::AM_REL))
		else $error("decoded result out of range");

	// an item held in the opcode stage is not lost while the result stage stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(opcode_s1)))
		else $error("opcode stage lost its item during a stall");

endmodule

// File: sv/c6502dec_decode.sv
// combinational opcode decode: instruction lookup and addressing mode rules
module c6502dec_decode (
	input  logic [c6502dec_pkg::OpcodeWidth-1:0] opcode,
	output c6502dec_pkg::dec_result_t            result
);

	logic [2:0] row;
	logic [2:0] col;
	logic [1:0] grp;
	logic       y_row;
	c6502dec_pkg::addr_mode_t mode;

	assign row = opcode[c6502dec_pkg::RowMsb:c6502dec_pkg::RowLsb];
	assign col = opcode[c6502dec_pkg::ColMsb:c6502dec_pkg::ColLsb];
	assign grp = opcode[c6502dec_pkg::GrpMsb:c6502dec_pkg::GrpLsb];

	// x-register ops in rows 4 and 5 swap the index register to y
	assign y_row = grp[1] && (row == c6502dec_pkg::RowStore || row == c6502dec_pkg::RowLoad);

	always_comb begin
		mode = c6502dec_pkg::AM_IMP;
		unique case (col)
			c6502dec_pkg::ColZpInd: begin
				if (grp == c6502dec_pkg::GrpCtl) begin
					if (row == c6502dec_pkg::RowBitJmp) mode = c6502dec_pkg::AM_ABS;
					else if (row <= c6502dec_pkg::RowLastImp) mode = c6502dec_pkg::AM_IMP;
					else mode = c6502dec_pkg::AM_IMM;
				end else if (grp == c6502dec_pkg::GrpRmw) begin
					mode = c6502dec_pkg::AM_IMM;
				end else begin
					mode = c6502dec_pkg::AM_IZX;
				end
			end
			c6502dec_pkg::ColZp: mode = c6502dec_pkg::AM_ZP;
			c6502dec_pkg::ColImm: begin
				if (grp == c6502dec_pkg::GrpCtl) mode = c6502dec_pkg::AM_IMP;
				else if (grp == c6502dec_pkg::GrpRmw)
					mode = (row <= c6502dec_pkg::RowLastImp) ? c6502dec_pkg::AM_ACC
						: c6502dec_pkg::AM_IMP;
				else mode = c6502dec_pkg::AM_IMM;
			end
			c6502dec_pkg::ColAbs: begin
				mode = (grp == c6502dec_pkg::GrpCtl && row == c6502dec_pkg::RowJmpInd)
					? c6502dec_pkg::AM_IND : c6502dec_pkg::AM_ABS;
			end
			c6502dec_pkg::ColIndY: begin
				if (grp == c6502dec_pkg::GrpCtl) mode = c6502dec_pkg::AM_REL;
				else if (grp == c6502dec_pkg::GrpRmw) mode = c6502dec_pkg::AM_IMP;
				else mode = c6502dec_pkg::AM_IZY;
			end
			c6502dec_pkg::ColZpIdx: mode = y_row ? c6502dec_pkg::AM_ZPY : c6502dec_pkg::AM_ZPX;
			c6502dec_pkg::ColAbsY: mode = grp[0] ? c6502dec_pkg::AM_ABY : c6502dec_pkg::AM_IMP;
			c6502dec_pkg::ColAbsIdx: mode = y_row ? c6502dec_pkg::AM_ABY : c6502dec_pkg::AM_ABX;
			default: mode = c6502dec_pkg::AM_IMP;
		endcase
	end

	assign result.code = c6502dec_pkg::INSN_TAB[{grp, row, col}];
	assign result.mode = mode;

endmodule

// File: test/cpu6502_decode_checker.sv
// checker for the 6502 opcode decoder: predicts each decode and compares the results
module cpu6502_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] opcode_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [6:0] instruction_code, [10:7] address_mode
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [c6502dec_pkg::CodeWidth-1:0] {
		OP_BRK, OP_NOP, OP_PHP, OP_BPL, OP_CLC, OP_JSR, OP_BIT, OP_PLP,
		OP_BMI, OP_SEC, OP_RTI, OP_PHA, OP_JMP, OP_BVC, OP_CLI, OP_RTS,
		OP_PLA, OP_BVS, OP_SEI, OP_STY, OP_DEY, OP_BCC, OP_TYA, OP_SHY,
		OP_LDY, OP_TAY, OP_BCS, OP_CLV, OP_CPY, OP_INY, OP_BNE, OP_CLD,
		OP_CPX, OP_INX, OP_BEQ, OP_SED, OP_ORA, OP_AND, OP_EOR, OP_ADC,
		OP_STA, OP_LDA, OP_CMP, OP_SBC, OP_JAM, OP_ASL, OP_ROL, OP_LSR,
		OP_ROR, OP_STX, OP_TXA, OP_TXS, OP_SHX, OP_LDX, OP_TAX, OP_TSX,
		OP_DEC, OP_DEX, OP_INC, OP_SLO, OP_ANC, OP_RLA, OP_SRE, OP_ALR,
		OP_RRA, OP_ARR, OP_SAX, OP_ANE, OP_SHA, OP_TAS, OP_LAX, OP_LXA,
		OP_LAS, OP_DCP, OP_SBX, OP_ISC, OP_USBC
	} insn_t;

	typedef struct packed {
		logic [7:0]               opcode;
		insn_t                    insn;
		c6502dec_pkg::addr_mode_t mode;
	} decode_t;

	// control group has no regular pattern, indexed by {row, column}
	localparam insn_t CtlByRowCol [64] = '{
		OP_BRK, OP_NOP, OP_PHP, OP_NOP, OP_BPL, OP_NOP, OP_CLC, OP_NOP,
		OP_JSR, OP_BIT, OP_PLP, OP_BIT, OP_BMI, OP_NOP, OP_SEC, OP_NOP,
		OP_RTI, OP_NOP, OP_PHA, OP_JMP, OP_BVC, OP_NOP, OP_CLI, OP_NOP,
		OP_RTS, OP_NOP, OP_PLA, OP_JMP, OP_BVS, OP_NOP, OP_SEI, OP_NOP,
		OP_NOP, OP_STY, OP_DEY, OP_STY, OP_BCC, OP_STY, OP_TYA, OP_SHY,
		OP_LDY, OP_LDY, OP_TAY, OP_LDY, OP_BCS, OP_LDY, OP_CLV, OP_LDY,
		OP_CPY, OP_CPY, OP_INY, OP_CPY, OP_BNE, OP_NOP, OP_CLD, OP_NOP,
		OP_CPX, OP_CPX, OP_INX, OP_CPX, OP_BEQ, OP_NOP, OP_SED, OP_NOP
	};
	localparam insn_t AluByRow [8] = '{
		OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC
	};
	localparam insn_t RmwByRow [8] = '{
		OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_STX, OP_LDX, OP_DEC, OP_INC
	};
	localparam insn_t IllByRow [8] = '{
		OP_SLO, OP_RLA, OP_SRE, OP_RRA, OP_SAX, OP_LAX, OP_DCP, OP_ISC
	};
	localparam insn_t IllImmByRow [8] = '{
		OP_ANC, OP_ANC, OP_ALR, OP_ARR, OP_ANE, OP_LXA, OP_SBX, OP_USBC
	};

	decode_t expected_decodes [$];

	function automatic insn_t insn_for(logic [2:0] row, logic [2:0] col, logic [1:0] grp);
		case (grp)
			c6502dec_pkg::GrpCtl: return CtlByRowCol[{row, col}];
			c6502dec_pkg::GrpAlu: begin
				if (row == c6502dec_pkg::RowStore && col == c6502dec_pkg::ColImm)
					return OP_NOP;
				return AluByRow[row];
			end
			c6502dec_pkg::GrpRmw: begin
				if (col == c6502dec_pkg::ColIndY)
					return OP_JAM;
				if (col == c6502dec_pkg::ColZpInd) begin
					if (row <= c6502dec_pkg::RowLastImp)
						return OP_JAM;
					return (row == c6502dec_pkg::RowLoad) ? OP_LDX : OP_NOP;
				end
				if (col == c6502dec_pkg::ColAbsY) begin
					if (row == c6502dec_pkg::RowStore)
						return OP_TXS;
					return (row == c6502dec_pkg::RowLoad) ? OP_TSX : OP_NOP;
				end
				if (col == c6502dec_pkg::ColImm && row > c6502dec_pkg::RowLastImp) begin
					case (row)
						c6502dec_pkg::RowStore: return OP_TXA;
						c6502dec_pkg::RowLoad:  return OP_TAX;
						3'd6:                   return OP_DEX;
						default:                return OP_NOP;
					endcase
				end
				if (row == c6502dec_pkg::RowStore && col == c6502dec_pkg::ColAbsIdx)
					return OP_SHX;
				return RmwByRow[row];
			end
			default: begin
				if (col == c6502dec_pkg::ColImm)
					return IllImmByRow[row];
				if (row == c6502dec_pkg::RowStore
					&& (col == c6502dec_pkg::ColIndY || col == c6502dec_pkg::ColAbsIdx))
					return OP_SHA;
				if (row == c6502dec_pkg::RowStore && col == c6502dec_pkg::ColAbsY)
					return OP_TAS;
				if (row == c6502dec_pkg::RowLoad && col == c6502dec_pkg::ColAbsY)
					return OP_LAS;
				return IllByRow[row];
			end
		endcase
	endfunction

	function automatic c6502dec_pkg::addr_mode_t mode_for(logic [2:0] row, logic [2:0] col,
		logic [1:0] grp);
		logic y_indexed;
		// stx/ldx style rows index with y instead of x
		y_indexed = grp[1] && (row == c6502dec_pkg::RowStore || row == c6502dec_pkg::RowLoad);
		case (col)
			c6502dec_pkg::ColZpInd: begin
				if (grp == c6502dec_pkg::GrpCtl) begin
					if (row == c6502dec_pkg::RowBitJmp)
						return c6502dec_pkg::AM_ABS;
					return (row <= c6502dec_pkg::RowLastImp) ? c6502dec_pkg::AM_IMP
						: c6502dec_pkg::AM_IMM;
				end
				return (grp == c6502dec_pkg::GrpRmw) ? c6502dec_pkg::AM_IMM
					: c6502dec_pkg::AM_IZX;
			end
			c6502dec_pkg::ColZp: return c6502dec_pkg::AM_ZP;
			c6502dec_pkg::ColImm: begin
				if (grp == c6502dec_pkg::GrpCtl)
					return c6502dec_pkg::AM_IMP;
				if (grp == c6502dec_pkg::GrpRmw)
					return (row <= c6502dec_pkg::RowLastImp) ? c6502dec_pkg::AM_ACC
						: c6502dec_pkg::AM_IMP;
				return c6502dec_pkg::AM_IMM;
			end
			c6502dec_pkg::ColAbs:
				return (grp == c6502dec_pkg::GrpCtl && row == c6502dec_pkg::RowJmpInd)
					? c6502dec_pkg::AM_IND : c6502dec_pkg::AM_ABS;
			c6502dec_pkg::ColIndY: begin
				if (grp == c6502dec_pkg::GrpCtl)
					return c6502dec_pkg::AM_REL;
				return (grp == c6502dec_pkg::GrpRmw) ? c6502dec_pkg::AM_IMP
					: c6502dec_pkg::AM_IZY;
			end
			c6502dec_pkg::ColZpIdx:
				return y_indexed ? c6502dec_pkg::AM_ZPY : c6502dec_pkg::AM_ZPX;
			c6502dec_pkg::ColAbsY:
				return grp[0] ? c6502dec_pkg::AM_ABY : c6502dec_pkg::AM_IMP;
			default: return y_indexed ? c6502dec_pkg::AM_ABY : c6502dec_pkg::AM_ABX;
		endcase
	endfunction

	function automatic decode_t decode_opcode(logic [7:0] op);
		decode_t d;
		d.opcode = op;
		d.insn   = insn_for(op[c6502dec_pkg::RowMsb:c6502dec_pkg::RowLsb],
			op[c6502dec_pkg::ColMsb:c6502dec_pkg::ColLsb],
			op[c6502dec_pkg::GrpMsb:c6502dec_pkg::GrpLsb]);
		d.mode   = mode_for(op[c6502dec_pkg::RowMsb:c6502dec_pkg::RowLsb],
			op[c6502dec_pkg::ColMsb:c6502dec_pkg::ColLsb],
			op[c6502dec_pkg::GrpMsb:c6502dec_pkg::GrpLsb]);
		return d;
	endfunction

	initial begin
		fail_count    = 0;
		pending_count = 0;
	end

	always @(posedge clk) begin
		decode_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_decodes.push_back(decode_opcode(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_decodes.size() == 0) begin
					$display("%0t: unexpected item, expected none, got data %h", $time, m_tdata);
					fail_count++;
				end else begin
					want = expected_decodes.pop_front();
					if (m_tdata[6:0] != want.insn) begin
						$display("%0t: opcode %h instruction expected %0d got %0d",
							$time, want.opcode, want.insn, m_tdata[6:0]);
						fail_count++;
					end
					if (m_tdata[10:7] != want.mode) begin
						$display("%0t: opcode %h mode expected %0d got %0d",
							$time, want.opcode, want.mode, m_tdata[10:7]);
						fail_count++;
					end
					if (m_tdata[15:11] != '0) begin
						$display("%0t: opcode %h padding expected 0 got %h",
							$time, want.opcode, m_tdata[15:11]);
						fail_count++;
					end
				end
			end
			pending_count = expected_decodes.size();
		end
	end

endmodule

// File: test/tb.sv
// testbench top for the 6502 opcode decoder: clock, reset, opcode stimulus and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 1750;
	localparam int CalmItems   = 250;
	localparam int HoldCycles  = 48;
	localparam int StuckLimit  = 1000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	int fail_count;
	int pending_count;
	int stuck_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	logic [7:0] corner_ops [24] = '{
		8'h00, 8'hFF, 8'h6C, 8'h89, 8'h01, 8'h11, 8'h4C, 8'h20,
		8'h02, 8'hF2, 8'h92, 8'h0A, 8'h96, 8'hB6, 8'hBE, 8'h9E,
		8'h9C, 8'h9B, 8'hBB, 8'h10, 8'hEB, 8'h80, 8'hA2, 8'h8B
	};

	always #5 clk = ~clk;

	cpu6502_opcode_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cpu6502_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	task automatic send_opcode(input logic [7:0] op);
		s_tvalid <= 1'b1;
		s_tdata  <= op;
		do @(posedge clk); while (!s_tready);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
	endtask

	// result side: random stall bursts, one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= StuckLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_ops[i])
			send_opcode(corner_ops[i]);
		wait_drained();

		// stall the result side while items keep coming so the pipe fills
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++)
			send_opcode(8'($urandom_range(0, 255)));

		for (int i = 16; i < RandomItems; i++) begin
			if (i == RandomItems - CalmItems)
				calm = 1'b1;
			send_opcode(8'($urandom_range(0, 255)));
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/c6502dec_pkg.sv
sv/c6502dec_decode.sv
sv/cpu6502_opcode_decoder_unit.sv
test/cpu6502_decode_checker.sv
test/tb.sv
